@@ rtl/core/hbd_pkg.sv @@
// Shared types and constants for the HTTP body deframer.
`timescale 1ns / 1ps

package hbd_pkg;

  // Default width of a chunk size in bits.
  localparam int SIZE_BITS_DEF = 32;

  // Widths of the configuration port.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BODY_MODE      = 2'd0,
    REG_CONTENT_LENGTH = 2'd1
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_FIXED   = 2'd0,
    MODE_CLOSE   = 2'd1,
    MODE_CHUNKED = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    PH_SIZE = 3'd0,
    PH_DATA = 3'd1,
    PH_CR   = 3'd2,
    PH_LF   = 3'd3,
    PH_LAST = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_BUSY      = 3'd0,
    ST_DONE      = 3'd1,
    ST_MISMATCH  = 3'd2,
    ST_MALFORMED = 3'd3,
    ST_TRAILER   = 3'd4
  } status_t;

  // Parser control state that travels between the state registers and the step logic.
  typedef struct packed {
    phase_t  phase;
    logic    digit_seen;
    logic    in_ext;
    logic    cr_seen;
    logic    line_nonempty;
    status_t sticky;
  } ctrl_t;

endpackage

@@ rtl/core/http_body_deframer.sv @@
// Top level of the HTTP body deframer: configuration, parser state and result register.
`timescale 1ns / 1ps

// Accepts one body byte per clock and returns one result per byte, in the cycle after
// the request is accepted. A new byte enters only when the result register is empty or
// its result leaves in the same cycle. A waiting result therefore holds off the input.
// With out_ready held high the sustained rate is one byte per clock, set by the parser
// state update on each accepted byte. Configure body_mode (index 0) and content_length
// (index 1) between bodies; reset clears the parser, so a new body starts after rst_n.
// Once status leaves in-progress it holds until reset and no further byte is consumed.
module http_body_deframer import hbd_pkg::*; #(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_byte_consumed,
  output logic                      out_payload_valid,
  output logic [7:0]                out_payload_byte,
  output logic [2:0]                out_status
);

  localparam int CNT_BITS = (SIZE_BITS > 32) ? SIZE_BITS : 32;

  mode_t                    body_mode_r;
  logic [CFG_DATA_BITS-1:0] content_length_r;
  ctrl_t                    ctrl_r;
  ctrl_t                    ctrl_nxt;
  logic [SIZE_BITS-1:0]     chunk_len_r;
  logic [SIZE_BITS-1:0]     chunk_len_nxt;
  logic [CNT_BITS-1:0]      bytes_seen_r;
  logic [CNT_BITS-1:0]      bytes_seen_nxt;
  logic                     consumed_nxt;
  logic                     pvalid_nxt;
  logic [7:0]               pbyte_nxt;
  status_t                  status_nxt;
  logic                     out_valid_r;
  logic                     out_consumed_r;
  logic                     out_pvalid_r;
  logic [7:0]               out_pbyte_r;
  status_t                  out_status_r;
  logic                     in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_mode_r      <= MODE_FIXED;
      content_length_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BODY_MODE:      body_mode_r      <= mode_t'(cfg_data[1:0]);
        REG_CONTENT_LENGTH: content_length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  hbd_step #(
    .SIZE_BITS(SIZE_BITS)
  ) u_step (
    .body_mode      (body_mode_r),
    .content_length (content_length_r),
    .ctrl_i         (ctrl_r),
    .chunk_len_i    (chunk_len_r),
    .bytes_seen_i   (bytes_seen_r),
    .byte_i         (in_byte),
    .ctrl_o         (ctrl_nxt),
    .chunk_len_o    (chunk_len_nxt),
    .bytes_seen_o   (bytes_seen_nxt),
    .consumed_o     (consumed_nxt),
    .valid_o        (pvalid_nxt),
    .pbyte_o        (pbyte_nxt),
    .status_o       (status_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r       <= '{phase: PH_SIZE, digit_seen: 1'b0, in_ext: 1'b0, cr_seen: 1'b0,
                        line_nonempty: 1'b0, sticky: ST_BUSY};
      chunk_len_r  <= '0;
      bytes_seen_r <= '0;
    end else if (in_fire) begin
      ctrl_r       <= ctrl_nxt;
      chunk_len_r  <= chunk_len_nxt;
      bytes_seen_r <= bytes_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_consumed_r <= consumed_nxt;
      out_pvalid_r   <= pvalid_nxt;
      out_pbyte_r    <= pbyte_nxt;
      out_status_r   <= status_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte_consumed = out_consumed_r;
  assign out_payload_valid = out_pvalid_r;
  assign out_payload_byte  = out_pbyte_r;
  assign out_status        = out_status_r;

`ifndef SYNTH
  a_payload_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_pvalid_r |-> out_consumed_r)
    else $error("payload byte reported without being consumed");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_pvalid_r |-> out_pbyte_r == 8'd0)
    else $error("payload byte nonzero without payload valid");

  a_sticky_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_r.sticky != ST_BUSY |=> ctrl_r.sticky == $past(ctrl_r.sticky))
    else $error("final status changed before reset");

  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_r.phase == PH_DATA |-> chunk_len_r != '0)
    else $error("data phase entered with a zero chunk size");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid_r)
    else $error("accepted request produced no result");
`endif

endmodule

@@ rtl/core/hbd_step.sv @@
// Per-byte next-state and result logic of the HTTP body deframer.
`timescale 1ns / 1ps

module hbd_step import hbd_pkg::*; #(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  mode_t                                  body_mode,
  input  logic [CFG_DATA_BITS-1:0]               content_length,
  input  ctrl_t                                  ctrl_i,
  input  logic [SIZE_BITS-1:0]                   chunk_len_i,
  input  logic [((SIZE_BITS > 32) ? SIZE_BITS : 32)-1:0] bytes_seen_i,
  input  logic [7:0]                             byte_i,
  output ctrl_t                                  ctrl_o,
  output logic [SIZE_BITS-1:0]                   chunk_len_o,
  output logic [((SIZE_BITS > 32) ? SIZE_BITS : 32)-1:0] bytes_seen_o,
  output logic                                   consumed_o,
  output logic                                   valid_o,
  output logic [7:0]                             pbyte_o,
  output status_t                                status_o
);

  localparam int CNT_BITS = (SIZE_BITS > 32) ? SIZE_BITS : 32;
  localparam logic [CNT_BITS-1:0] SIZE_MASK = CNT_BITS'((65'd1 << SIZE_BITS) - 65'd1);

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;
  localparam logic [7:0] HEX_TEN = 8'd10;

  logic                is_cr;
  logic                is_lf;
  logic                hex_ok;
  logic [3:0]          hex_val;
  logic [CNT_BITS-1:0] cl_ext;
  logic [CNT_BITS-1:0] chunk_ext;
  logic [CNT_BITS-1:0] bs_plus;
  logic [CNT_BITS-1:0] bs_wrap;

  assign is_cr     = (byte_i == CH_CR);
  assign is_lf     = (byte_i == CH_LF);
  assign cl_ext    = CNT_BITS'(content_length);
  assign chunk_ext = CNT_BITS'(chunk_len_i);
  assign bs_plus   = bytes_seen_i + CNT_BITS'(1);
  assign bs_wrap   = bs_plus & SIZE_MASK;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (byte_i >= CH_ZERO && byte_i <= CH_NINE) begin
      hex_val = 4'(byte_i - CH_ZERO);
    end else if (byte_i >= CH_LA && byte_i <= CH_LF_HEX) begin
      hex_val = 4'(byte_i - CH_LA + HEX_TEN);
    end else if (byte_i >= CH_UA && byte_i <= CH_UF) begin
      hex_val = 4'(byte_i - CH_UA + HEX_TEN);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // Next state.
  always_comb begin
    ctrl_o       = ctrl_i;
    chunk_len_o  = chunk_len_i;
    bytes_seen_o = bytes_seen_i;
    if (ctrl_i.sticky == ST_BUSY) begin
      case (body_mode)
        MODE_FIXED: begin
          if (bytes_seen_i >= cl_ext) begin
            ctrl_o.sticky = ST_DONE;
          end else begin
            bytes_seen_o = bs_plus;
            if (bs_plus >= cl_ext) begin
              ctrl_o.sticky = ST_DONE;
            end
          end
        end
        MODE_CHUNKED: begin
          case (ctrl_i.phase)
            PH_SIZE: begin
              if (ctrl_i.cr_seen && is_lf) begin
                if (!ctrl_i.digit_seen) begin
                  ctrl_o.sticky = ST_MALFORMED;
                end else if (chunk_len_i != '0) begin
                  ctrl_o.phase = PH_DATA;
                  bytes_seen_o = '0;
                end else begin
                  ctrl_o.phase = PH_LAST;
                end
                ctrl_o.digit_seen    = 1'b0;
                ctrl_o.in_ext        = 1'b0;
                ctrl_o.cr_seen       = 1'b0;
                ctrl_o.line_nonempty = 1'b0;
              end else if (is_cr) begin
                ctrl_o.cr_seen = 1'b1;
                ctrl_o.in_ext  = 1'b1;
              end else begin
                ctrl_o.cr_seen = 1'b0;
                if (!ctrl_i.in_ext && hex_ok) begin
                  // Another digit would push the size past its width.
                  if (chunk_len_i[SIZE_BITS-1 -: 4] != 4'd0) begin
                    ctrl_o.sticky = ST_MALFORMED;
                  end else begin
                    chunk_len_o       = {chunk_len_i[SIZE_BITS-5:0], hex_val};
                    ctrl_o.digit_seen = 1'b1;
                  end
                end else begin
                  ctrl_o.in_ext = 1'b1;
                end
              end
            end
            PH_DATA: begin
              bytes_seen_o = bs_wrap;
              if (bs_wrap >= chunk_ext) begin
                ctrl_o.phase = PH_CR;
              end
            end
            PH_CR: begin
              if (is_cr) begin
                ctrl_o.phase = PH_LF;
              end else begin
                ctrl_o.sticky = ST_MISMATCH;
              end
            end
            PH_LF: begin
              if (is_lf) begin
                ctrl_o.phase         = PH_SIZE;
                chunk_len_o          = '0;
                bytes_seen_o         = '0;
                ctrl_o.digit_seen    = 1'b0;
                ctrl_o.in_ext        = 1'b0;
                ctrl_o.cr_seen       = 1'b0;
                ctrl_o.line_nonempty = 1'b0;
              end else begin
                ctrl_o.sticky = ST_MISMATCH;
              end
            end
            default: begin
              // Line after the last chunk: empty ends the body, anything else is a trailer.
              if (ctrl_i.cr_seen && is_lf) begin
                ctrl_o.sticky        = ctrl_i.line_nonempty ? ST_TRAILER : ST_DONE;
                ctrl_o.digit_seen    = 1'b0;
                ctrl_o.in_ext        = 1'b0;
                ctrl_o.cr_seen       = 1'b0;
                ctrl_o.line_nonempty = 1'b0;
              end else begin
                if (ctrl_i.cr_seen || !is_cr) begin
                  ctrl_o.line_nonempty = 1'b1;
                end
                ctrl_o.cr_seen = is_cr;
              end
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // Result of this byte.
  always_comb begin
    consumed_o = 1'b0;
    valid_o    = 1'b0;
    if (ctrl_i.sticky == ST_BUSY) begin
      case (body_mode)
        MODE_FIXED: begin
          consumed_o = (bytes_seen_i < cl_ext);
          valid_o    = (bytes_seen_i < cl_ext);
        end
        MODE_CHUNKED: begin
          case (ctrl_i.phase)
            PH_DATA: begin
              consumed_o = 1'b1;
              valid_o    = 1'b1;
            end
            PH_CR:   consumed_o = is_cr;
            PH_LF:   consumed_o = is_lf;
            default: consumed_o = 1'b1;
          endcase
        end
        default: begin
          consumed_o = 1'b1;
          valid_o    = 1'b1;
        end
      endcase
    end
  end

  assign pbyte_o  = valid_o ? byte_i : 8'd0;
  assign status_o = ctrl_o.sticky;

endmodule
